FILE: design/lc3s_pkg.sv
// Package for the LC-3 instruction step unit: request codes, status codes, opcodes,
// the queued request type and the result type.
// No dependencies.
package lc3s_pkg;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_EXEC    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRAP    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_HALTED  = 2'd3;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [15:0] PC_RESET = 16'h3000;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_write;
        logic        is_exec;
        logic        is_restart;
        logic [15:0] addr;
        logic [15:0] data;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc_value;
        logic [15:0] instruction_word;
        logic [2:0]  cond_flags;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        store_done;
        logic [15:0] store_address;
        logic [15:0] store_data;
    } res_t;

    function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 16; i++)
        begin
            if (i >= bits)
            begin
                r[i] = v[bits - 1];
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0)
        begin
            f = 3'b010;
        end
        else if (v[15])
        begin
            f = 3'b100;
        end
        else
        begin
            f = 3'b001;
        end
        return f;
    endfunction

endpackage

FILE: design/lc3s_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
interface lc3s_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] load_address;
    logic [15:0] load_data;
    modport source (output valid, req_type, load_address, load_data, input ready);
    modport sink (input valid, req_type, load_address, load_data, output ready);
endinterface

interface lc3s_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] pc_value;
    logic [15:0] instruction_word;
    logic [2:0]  cond_flags;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        store_done;
    logic [15:0] store_address;
    logic [15:0] store_data;
    modport source (output valid, status, pc_value, instruction_word, cond_flags,
                    reg_written, reg_index, reg_value, store_done, store_address,
                    store_data, input ready);
    modport sink (input valid, status, pc_value, instruction_word, cond_flags,
                  reg_written, reg_index, reg_value, store_done, store_address,
                  store_data, output ready);
endinterface

FILE: design/lc3s_front.sv
// Front end: accepts request items, classifies them and queues them (two entries).
// Depends on lc3s_pkg and lc3s_if.
module lc3s_front
(
    input  logic                clk,
    input  logic                rst_n,
    lc3s_req_if.sink            req,
    output lc3s_pkg::req_t      q_data,
    output logic                q_valid,
    input  logic                q_pop
);
    lc3s_pkg::req_t  mem_reg [2];
    logic            wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    lc3s_pkg::req_t  cls;
    logic            push;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = mem_reg[rp_reg];

    always_comb
    begin
        cls.is_write   = (req.req_type == lc3s_pkg::REQ_WRITE);
        cls.is_exec    = (req.req_type == lc3s_pkg::REQ_EXEC);
        cls.is_restart = (req.req_type == lc3s_pkg::REQ_RESTART);
        cls.addr       = req.load_address;
        cls.data       = req.load_data;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cls;
        end
    end
endmodule

FILE: design/lc3s_back.sv
// Back end: sequencer that carries out one queued request, owning memory and registers.
// Depends on lc3s_pkg.
module lc3s_back #(
    parameter int ADDR_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        start_pc,
    input  lc3s_pkg::req_t     q_data,
    input  logic               q_valid,
    output logic               q_pop,
    output lc3s_pkg::res_t     res_data,
    output logic               res_valid,
    input  logic               res_ready
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_DEC   = 6'b000100,
        S_IND   = 6'b001000,
        S_MEM   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    logic [15:0] mem [2**ADDR_BITS];
    logic [15:0] rd_data;
    logic [ADDR_BITS-1:0] rd_addr;
    logic        wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [15:0] wr_data;

    state_t      state_reg, state_next;
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic        halt_reg, halt_next;
    logic [15:0] ir_reg, ir_next;
    logic        rvalid_reg, rvalid_next;
    lc3s_pkg::res_t res_reg, res_next;
    logic        rf_we;
    logic [2:0]  rf_wi;
    logic [15:0] rf_wd;
    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [15:0] pcoff9, base6, t;
    logic        out_free;

    assign res_data  = res_reg;
    assign res_valid = rvalid_reg;
    assign out_free  = !rvalid_reg || res_ready;
    assign op  = ir_reg[15:12];
    assign dr  = ir_reg[11:9];
    assign sr1 = ir_reg[8:6];
    assign pcoff9 = pc_reg + lc3s_pkg::sext(ir_reg, 9);
    assign base6  = rf_reg[sr1] + lc3s_pkg::sext(ir_reg, 6);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        cc_next     = cc_reg;
        halt_next   = halt_reg;
        ir_next     = ir_reg;
        rvalid_next = rvalid_reg && !res_ready;
        res_next    = res_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = q_data.addr[ADDR_BITS-1:0];
        wr_data     = q_data.data;
        rd_addr     = pc_reg[ADDR_BITS-1:0];
        rf_we       = 1'b0;
        rf_wi       = dr;
        rf_wd       = 16'd0;
        t           = 16'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    res_next = '0;
                    res_next.cond_flags = cc_reg;
                    if (q_data.is_write)
                    begin
                        wr_en = 1'b1;
                        res_next.pc_value = pc_reg;
                        rvalid_next = 1'b1;
                    end
                    else if (q_data.is_restart)
                    begin
                        pc_next = start_pc;
                        halt_next = 1'b0;
                        res_next.pc_value = start_pc;
                        rvalid_next = 1'b1;
                    end
                    else if (q_data.is_exec && !halt_reg)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        if (q_data.is_exec)
                        begin
                            res_next.status = lc3s_pkg::ST_HALTED;
                        end
                        res_next.pc_value = pc_reg;
                        rvalid_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                // rd_data now holds the instruction word
                ir_next = rd_data;
                pc_next = pc_reg + 16'd1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                res_next.instruction_word = ir_reg;
                res_next.pc_value = pc_reg;
                state_next = S_DONE;
                case (op)
                    lc3s_pkg::OP_ADD, lc3s_pkg::OP_AND:
                    begin
                        t = ir_reg[5] ? lc3s_pkg::sext(ir_reg, 5) : rf_reg[ir_reg[2:0]];
                        rf_wd = (op == lc3s_pkg::OP_ADD) ? rf_reg[sr1] + t : rf_reg[sr1] & t;
                        rf_we = 1'b1;
                    end
                    lc3s_pkg::OP_NOT:
                    begin
                        rf_wd = ~rf_reg[sr1];
                        rf_we = 1'b1;
                    end
                    lc3s_pkg::OP_LEA:
                    begin
                        rf_wd = pcoff9;
                        rf_we = 1'b1;
                    end
                    lc3s_pkg::OP_BR:
                    begin
                        if ((dr & cc_reg) != 3'd0)
                        begin
                            pc_next = pcoff9;
                            res_next.pc_value = pcoff9;
                        end
                    end
                    lc3s_pkg::OP_JMP:
                    begin
                        pc_next = rf_reg[sr1];
                        res_next.pc_value = rf_reg[sr1];
                    end
                    lc3s_pkg::OP_JSR:
                    begin
                        t = ir_reg[11] ? pc_reg + lc3s_pkg::sext(ir_reg, 11) : rf_reg[sr1];
                        pc_next = t;
                        res_next.pc_value = t;
                        res_next.reg_written = 1'b1;
                        res_next.reg_index = 3'd7;
                        res_next.reg_value = pc_reg;
                        rf_we = 1'b1;
                        rf_wi = 3'd7;
                        rf_wd = pc_reg;
                    end
                    lc3s_pkg::OP_LD, lc3s_pkg::OP_LDI:
                    begin
                        rd_addr = pcoff9[ADDR_BITS-1:0];
                        state_next = (op == lc3s_pkg::OP_LDI) ? S_IND : S_MEM;
                    end
                    lc3s_pkg::OP_LDR:
                    begin
                        rd_addr = base6[ADDR_BITS-1:0];
                        state_next = S_MEM;
                    end
                    lc3s_pkg::OP_ST, lc3s_pkg::OP_STR:
                    begin
                        t = (op == lc3s_pkg::OP_STR) ? base6 : pcoff9;
                        wr_en = 1'b1;
                        wr_addr = t[ADDR_BITS-1:0];
                        wr_data = rf_reg[dr];
                        res_next.store_done = 1'b1;
                        res_next.store_address = t;
                        res_next.store_data = rf_reg[dr];
                    end
                    lc3s_pkg::OP_STI:
                    begin
                        rd_addr = pcoff9[ADDR_BITS-1:0];
                        state_next = S_IND;
                    end
                    lc3s_pkg::OP_TRAP:
                    begin
                        res_next.status = lc3s_pkg::ST_TRAP;
                    end
                    default:
                    begin
                        res_next.status = lc3s_pkg::ST_ILLEGAL;
                        halt_next = 1'b1;
                    end
                endcase
                if (rf_we && op != lc3s_pkg::OP_JSR)
                begin
                    cc_next = lc3s_pkg::flags_of(rf_wd);
                    res_next.reg_written = 1'b1;
                    res_next.reg_index = dr;
                    res_next.reg_value = rf_wd;
                end
                res_next.cond_flags = rf_we && op != lc3s_pkg::OP_JSR ?
                                      lc3s_pkg::flags_of(rf_wd) : cc_reg;
                if (state_next == S_DONE)
                begin
                    rvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_IND:
            begin
                if (op == lc3s_pkg::OP_STI)
                begin
                    wr_en = 1'b1;
                    wr_addr = rd_data[ADDR_BITS-1:0];
                    wr_data = rf_reg[dr];
                    res_next.store_done = 1'b1;
                    res_next.store_address = rd_data;
                    res_next.store_data = rf_reg[dr];
                    rvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr = rd_data[ADDR_BITS-1:0];
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                rf_we = 1'b1;
                rf_wd = rd_data;
                cc_next = lc3s_pkg::flags_of(rd_data);
                res_next.cond_flags = lc3s_pkg::flags_of(rd_data);
                res_next.reg_written = 1'b1;
                res_next.reg_index = dr;
                res_next.reg_value = rd_data;
                rvalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= lc3s_pkg::PC_RESET;
            cc_reg     <= 3'd0;
            halt_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            cc_reg     <= cc_next;
            halt_reg   <= halt_next;
            rvalid_reg <= rvalid_next;
            if (rf_we)
            begin
                rf_reg[rf_wi] <= rf_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg  <= ir_next;
        res_reg <= res_next;
    end
endmodule

FILE: design/lc3_instruction_step_unit.sv
// LC-3 instruction step unit, top level.
// Channels: req (valid/ready; req_type, load_address, load_data) and res (valid/ready;
// one result item per request). start_pc is written through cfg_we/cfg_data; the user
// must do so only while idle, as the block does not enforce it. A front end queues up
// to two request items; the back end sequences each through the synchronous memory,
// which has one read port and one write port. Non-execute and halted requests finish
// in the idle state; execute items pass through fetch and decode, LD and LDR then add a
// memory read state, STI an indirect state and LDI both. The back end takes a new item
// from the queue only in its idle state, once its result register is free.
// Reset clears the queue, registers, condition code and halt flag and loads PC with
// 0x3000 and start_pc with 0x3000; memory contents are undefined until written.
// When the receiver stalls, the result holds in its register and the queue fills; then
// req.ready drops.
// Depends on lc3s_pkg, lc3s_if, lc3s_front, lc3s_back.
module lc3_instruction_step_unit #(
    parameter int ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    lc3s_req_if.sink    req,
    lc3s_res_if.source  res
);
    logic [15:0]    start_pc_reg;
    lc3s_pkg::req_t q_data;
    logic           q_valid, q_pop;
    lc3s_pkg::res_t r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= lc3s_pkg::PC_RESET;
        end
        else if (cfg_we)
        begin
            start_pc_reg <= cfg_data;
        end
    end

    lc3s_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    lc3s_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .start_pc(start_pc_reg),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
        .res_data(r), .res_valid(res.valid), .res_ready(res.ready)
    );

    assign res.status           = r.status;
    assign res.pc_value         = r.pc_value;
    assign res.instruction_word = r.instruction_word;
    assign res.cond_flags       = r.cond_flags;
    assign res.reg_written      = r.reg_written;
    assign res.reg_index        = r.reg_index;
    assign res.reg_value        = r.reg_value;
    assign res.store_done       = r.store_done;
    assign res.store_address    = r.store_address;
    assign res.store_data       = r.store_data;
endmodule

FILE: verif/tb_lc3_instruction_step_unit.sv
// Testbench for lc3_instruction_step_unit: loads programs, executes, restarts and
// checks every result item against an in-bench predictor of the LC-3 core.
// Depends on lc3s_pkg, lc3s_if and the unit's RTL.
`timescale 1ns / 100ps

module tb_lc3_instruction_step_unit;

    localparam logic [3:0] OP_RTI = 4'h8;
    localparam logic [3:0] OP_RESERVED = 4'hD;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [3:0] LEGAL_OPS [14] = '{
        lc3s_pkg::OP_BR, lc3s_pkg::OP_ADD, lc3s_pkg::OP_LD, lc3s_pkg::OP_ST,
        lc3s_pkg::OP_JSR, lc3s_pkg::OP_AND, lc3s_pkg::OP_LDR, lc3s_pkg::OP_STR,
        lc3s_pkg::OP_NOT, lc3s_pkg::OP_LDI, lc3s_pkg::OP_STI, lc3s_pkg::OP_JMP,
        lc3s_pkg::OP_LEA, lc3s_pkg::OP_TRAP};

    typedef struct {
        logic [1:0]     rt;
        logic [15:0]    la;
        logic [15:0]    ld;
        lc3s_pkg::res_t expd;
    } pend_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    lc3s_req_if req_ch();
    lc3s_res_if res_ch();

    lc3_instruction_step_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch.source),
        .res      (res_ch.sink)
    );

    // shadow core state
    logic [15:0] core_mem [0:65535];
    bit          mem_written [0:65535];
    logic [15:0] core_regs [8];
    logic [15:0] core_pc;
    logic [2:0]  core_cc;
    bit          core_halted;
    logic [15:0] core_start;

    pend_item_t     pending_q[$];
    lc3s_pkg::res_t expected_res_q[$];
    lc3s_pkg::res_t in_flight_res;
    int          queued_count;
    int          sent_count;
    int          recv_count;
    int          mismatches;
    int          exec_count;
    int          store_count;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [2:0] cc_from(input logic [15:0] v);
        if (v == 16'd0)
        begin
            return 3'b010;
        end
        return v[15] ? 3'b100 : 3'b001;
    endfunction

    function automatic lc3s_pkg::res_t predict_item(input logic [1:0] rt,
                                                    input logic [15:0] la,
                                                    input logic [15:0] ld);
        lc3s_pkg::res_t r;
        logic [15:0] w;
        logic [15:0] npc;
        logic [15:0] a;
        logic [15:0] t;
        logic [2:0]  dr;
        logic [2:0]  sr;
        r = '0;
        case (rt)
            lc3s_pkg::REQ_WRITE:
            begin
                core_mem[la] = ld;
                mem_written[la] = 1'b1;
            end
            lc3s_pkg::REQ_RESTART:
            begin
                core_pc = core_start;
                core_halted = 1'b0;
            end
            lc3s_pkg::REQ_EXEC:
            begin
                if (core_halted)
                begin
                    r.status = lc3s_pkg::ST_HALTED;
                end
                else
                begin
                    w = core_mem[core_pc];
                    r.instruction_word = w;
                    core_pc = core_pc + 16'd1;
                    npc = core_pc;
                    dr = w[11:9];
                    sr = w[8:6];
                    case (w[15:12])
                        lc3s_pkg::OP_ADD, lc3s_pkg::OP_AND:
                        begin
                            t = w[5] ? {{11{w[4]}}, w[4:0]} : core_regs[w[2:0]];
                            r.reg_value = (w[15:12] == lc3s_pkg::OP_ADD)
                                          ? core_regs[sr] + t : core_regs[sr] & t;
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_NOT:
                        begin
                            r.reg_value = ~core_regs[sr];
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_BR:
                        begin
                            if ((dr & core_cc) != 3'd0)
                            begin
                                core_pc = npc + {{7{w[8]}}, w[8:0]};
                            end
                        end
                        lc3s_pkg::OP_JMP:
                        begin
                            core_pc = core_regs[sr];
                        end
                        lc3s_pkg::OP_JSR:
                        begin
                            // target taken before R7 gets the return address
                            t = w[11] ? npc + {{5{w[10]}}, w[10:0]} : core_regs[sr];
                            core_pc = t;
                            r.reg_written = 1'b1;
                            r.reg_index = 3'd7;
                            r.reg_value = npc;
                        end
                        lc3s_pkg::OP_LD:
                        begin
                            r.reg_value = core_mem[npc + {{7{w[8]}}, w[8:0]}];
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_LDI:
                        begin
                            r.reg_value = core_mem[core_mem[npc + {{7{w[8]}}, w[8:0]}]];
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_LDR:
                        begin
                            r.reg_value = core_mem[core_regs[sr] + {{10{w[5]}}, w[5:0]}];
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_LEA:
                        begin
                            r.reg_value = npc + {{7{w[8]}}, w[8:0]};
                            r.reg_written = 1'b1;
                            r.reg_index = dr;
                        end
                        lc3s_pkg::OP_ST, lc3s_pkg::OP_STI, lc3s_pkg::OP_STR:
                        begin
                            if (w[15:12] == lc3s_pkg::OP_STR)
                            begin
                                a = core_regs[sr] + {{10{w[5]}}, w[5:0]};
                            end
                            else
                            begin
                                a = npc + {{7{w[8]}}, w[8:0]};
                            end
                            if (w[15:12] == lc3s_pkg::OP_STI)
                            begin
                                a = core_mem[a];
                            end
                            r.store_data = core_regs[dr];
                            core_mem[a] = core_regs[dr];
                            mem_written[a] = 1'b1;
                            r.store_done = 1'b1;
                            r.store_address = a;
                        end
                        lc3s_pkg::OP_TRAP:
                        begin
                            r.status = lc3s_pkg::ST_TRAP;
                        end
                        default:
                        begin
                            r.status = lc3s_pkg::ST_ILLEGAL;
                            core_halted = 1'b1;
                        end
                    endcase
                    if (r.reg_written)
                    begin
                        core_regs[r.reg_index] = r.reg_value;
                        if (w[15:12] != lc3s_pkg::OP_JSR)
                        begin
                            core_cc = cc_from(r.reg_value);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.pc_value = core_pc;
        r.cond_flags = core_cc;
        return r;
    endfunction

    task automatic push_item(input logic [1:0] rt, input logic [15:0] la,
                             input logic [15:0] ld);
        pend_item_t p;
        p.rt = rt;
        p.la = la;
        p.ld = ld;
        p.expd = predict_item(rt, la, ld);
        pending_q.push_back(p);
        queued_count++;
    endtask

    task automatic fill_word(input logic [15:0] addr);
        if (!mem_written[addr])
        begin
            push_item(lc3s_pkg::REQ_WRITE, addr, 16'($urandom));
        end
    endtask

    function automatic logic [15:0] random_insn();
        logic [15:0] w;
        int          p;
        w = 16'($urandom);
        p = $urandom_range(0, 99);
        if (p < 4)
        begin
            w[15:12] = (p < 2) ? OP_RTI : OP_RESERVED;
        end
        else
        begin
            w[15:12] = LEGAL_OPS[$urandom_range(0, 13)];
        end
        return w;
    endfunction

    // queues one execute item, first loading every word it will read
    task automatic queue_exec(input bit fresh, input logic [15:0] word);
        logic [15:0] w;
        logic [15:0] a;
        if (!core_halted)
        begin
            if (fresh || !mem_written[core_pc])
            begin
                push_item(lc3s_pkg::REQ_WRITE, core_pc, fresh ? word : random_insn());
            end
            w = core_mem[core_pc];
            a = core_pc + 16'd1 + {{7{w[8]}}, w[8:0]};
            case (w[15:12])
                lc3s_pkg::OP_LD:
                begin
                    fill_word(a);
                end
                lc3s_pkg::OP_LDI:
                begin
                    fill_word(a);
                    fill_word(core_mem[a]);
                end
                lc3s_pkg::OP_STI:
                begin
                    fill_word(a);
                end
                lc3s_pkg::OP_LDR:
                begin
                    fill_word(core_regs[w[8:6]] + {{10{w[5]}}, w[5:0]});
                end
                default:
                begin
                end
            endcase
        end
        push_item(lc3s_pkg::REQ_EXEC, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || req_ch.valid || expected_res_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_start(input logic [15:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= v;
        core_start = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // queues about n request items
    task automatic random_phase(input int n);
        int p;
        int stop;
        stop = queued_count + n;
        push_item(lc3s_pkg::REQ_RESTART, 16'($urandom), 16'($urandom));
        while (queued_count < stop)
        begin
            p = $urandom_range(0, 99);
            if (p < 72)
            begin
                queue_exec($urandom_range(0, 1), random_insn());
            end
            else if (p < 88)
            begin
                push_item(lc3s_pkg::REQ_WRITE, 16'($urandom), 16'($urandom));
            end
            else if (p < 96)
            begin
                push_item(lc3s_pkg::REQ_RESTART, 16'($urandom), 16'($urandom));
            end
            else
            begin
                push_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    function automatic int sender_idle_pct(input int cnt);
        int mode;
        mode = (cnt / 64) % 4;
        return (mode == 1) ? 46 : (mode == 3) ? 34 : 0;
    endfunction

    function automatic int receiver_stall_pct(input int cnt);
        int mode;
        mode = (cnt / 64) % 4;
        return (mode == 2) ? 46 : (mode == 3) ? 34 : 0;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!(req_ch.valid && !req_ch.ready))
        begin
            if (req_ch.valid)
            begin
                expected_res_q.push_back(in_flight_res);
                sent_count++;
            end
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct(sent_count))
            begin
                req_ch.valid <= 1'b1;
                req_ch.req_type <= pending_q[0].rt;
                req_ch.load_address <= pending_q[0].la;
                req_ch.load_data <= pending_q[0].ld;
                in_flight_res = pending_q[0].expd;
                void'(pending_q.pop_front());
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        lc3s_pkg::res_t act;
        lc3s_pkg::res_t expd;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                act.status = res_ch.status;
                act.pc_value = res_ch.pc_value;
                act.instruction_word = res_ch.instruction_word;
                act.cond_flags = res_ch.cond_flags;
                act.reg_written = res_ch.reg_written;
                act.reg_index = res_ch.reg_index;
                act.reg_value = res_ch.reg_value;
                act.store_done = res_ch.store_done;
                act.store_address = res_ch.store_address;
                act.store_data = res_ch.store_data;
                recv_count++;
                if (expected_res_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result item %0d: %p", recv_count, act);
                    end
                end
                else
                begin
                    expd = expected_res_q.pop_front();
                    if (act.instruction_word != 16'd0 && expd.status != lc3s_pkg::ST_HALTED)
                    begin
                        exec_count++;
                    end
                    if (expd.store_done)
                    begin
                        store_count++;
                    end
                    if (act.status !== expd.status || act.pc_value !== expd.pc_value
                        || act.instruction_word !== expd.instruction_word
                        || act.cond_flags !== expd.cond_flags
                        || act.reg_written !== expd.reg_written
                        || act.reg_index !== expd.reg_index
                        || act.reg_value !== expd.reg_value
                        || act.store_done !== expd.store_done
                        || act.store_address !== expd.store_address
                        || act.store_data !== expd.store_data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch on item %0d", recv_count);
                            $display("  expected %p", expd);
                            $display("  actual   %p", act);
                        end
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct(recv_count));
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_res_q.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 16'd0;
        req_ch.valid = 1'b0;
        req_ch.req_type = lc3s_pkg::REQ_WRITE;
        req_ch.load_address = 16'd0;
        req_ch.load_data = 16'd0;
        res_ch.ready = 1'b0;
        idle_cycles = 0;
        queued_count = 0;
        sent_count = 0;
        recv_count = 0;
        mismatches = 0;
        exec_count = 0;
        store_count = 0;
        for (int i = 0; i < 65536; i++)
        begin
            mem_written[i] = 1'b0;
            core_mem[i] = 16'd0;
        end
        for (int i = 0; i < 8; i++)
        begin
            core_regs[i] = 16'd0;
        end
        core_start = lc3s_pkg::PC_RESET;
        core_pc = lc3s_pkg::PC_RESET;
        core_cc = 3'd0;
        core_halted = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, field extremes, halt and restart paths
        queue_exec(1, 16'h0E05);             // BRnzp with reset flags: not taken
        queue_exec(1, 16'h1270);             // ADD R1,R1,#-16
        queue_exec(1, 16'h1441);             // ADD R2,R1,R1
        queue_exec(1, 16'h56AF);             // AND R3,R2,#15
        queue_exec(1, 16'h98FF);             // NOT R4,R3
        queue_exec(1, 16'h0E00);             // BRnzp taken, zero offset
        queue_exec(1, 16'hEB00);             // LEA R5,#-256
        queue_exec(1, 16'h2CFF);             // LD R6,#255
        queue_exec(1, 16'hA002);             // LDI R0
        queue_exec(1, 16'h6F20);             // LDR R7,R4,#-32
        queue_exec(1, 16'h3203);             // ST R1
        queue_exec(1, 16'hB5FF);             // STI R2
        queue_exec(1, 16'h775F);             // STR R3,R5,#31
        queue_exec(1, 16'h4BFF);             // JSR +1023
        queue_exec(1, 16'h41C0);             // JSRR R7, target read first
        queue_exec(1, 16'hC1C0);             // RET
        queue_exec(1, 16'hF025);             // TRAP, reported only
        queue_exec(1, {OP_RTI, 12'h000});    // RTI halts
        queue_exec(0, 16'd0);                // execute while halted
        push_item(lc3s_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF);
        push_item(lc3s_pkg::REQ_WRITE, 16'h0000, 16'h0000);
        push_item(lc3s_pkg::REQ_RESTART, 16'd0, 16'd0);
        queue_exec(1, {OP_RESERVED, 12'hFFF});
        push_item(lc3s_pkg::REQ_RESTART, 16'hFFFF, 16'hFFFF);
        push_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
        random_phase(200);

        write_start(16'h0000);
        random_phase(200);
        write_start(16'hFFFF);
        random_phase(200);
        write_start(16'($urandom));
        random_phase(200);

        wait_drained();
        if (expected_res_q.size() != 0)
        begin
            mismatches++;
        end
        $display("%0d request items sent, %0d results checked, %0d instructions run",
                 sent_count, recv_count, exec_count);
        $display("%0d stores, four start addresses, %0d mismatches", store_count, mismatches);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
